### hw/rtl/mrft_pkg.sv
// Shared types and constants for the mesh route forwarding table.
// Holds opcodes, result codes, the route entry layout and the command and status structs.
// Depends on nothing; every other file but mrft_ram refers to it by scoped names.
`default_nettype none

package mrft_pkg;

  localparam int ROUTE_ENTRIES_DEF = 16;
  localparam int PEER_SLOTS_DEF    = 8;

  localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;

  typedef enum logic [2:0] {
    OP_OFFER  = 3'd0,
    OP_DELETE = 3'd1,
    OP_HELLO  = 3'd2,
    OP_DOWN   = 3'd3,
    OP_FWD    = 3'd4,
    OP_LOCAL  = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    RC_ADDED    = 4'd0,
    RC_IMPROVED = 4'd1,
    RC_KEPT     = 4'd2,
    RC_FULL     = 4'd3,
    RC_SELF     = 4'd4,
    RC_REMOVED  = 4'd5,
    RC_ABSENT   = 4'd6,
    RC_PEER_SET = 4'd7,
    RC_LOCAL    = 4'd8,
    RC_FORWARD  = 4'd9,
    RC_EXPIRED  = 4'd10,
    RC_NO_ROUTE = 4'd11,
    RC_BAD      = 4'd12
  } rc_e;

  typedef struct packed {
    logic [31:0] dest;
    logic [2:0]  peer;
    logic [7:0]  hops;
  } route_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } mrft_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic out_busy;
  } mrft_sts_t;

endpackage

`default_nettype wire

### hw/rtl/mrft_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Used for the route entries and the peer addresses; depends on nothing.
`default_nettype none

module mrft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/mrft_ctrl.sv
// Controller state machine of the mesh route forwarding table.
// Sequences accept, table scan, drain and finish; depends on mrft_pkg.
`default_nettype none

module mrft_ctrl #(
  parameter int ROUTE_ENTRIES = mrft_pkg::ROUTE_ENTRIES_DEF,
  parameter int PEER_SLOTS    = mrft_pkg::PEER_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mrft_pkg::mrft_sts_t sts_i,
  output mrft_pkg::mrft_cmd_t      cmd_o,
  output logic [$clog2((ROUTE_ENTRIES > PEER_SLOTS) ? ROUTE_ENTRIES : PEER_SLOTS)-1:0]
                                   scan_idx_o
);

  localparam int N_SCAN = (ROUTE_ENTRIES > PEER_SLOTS) ? ROUTE_ENTRIES : PEER_SLOTS;
  localparam int SW     = $clog2(N_SCAN);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic last_idx;

  assign last_idx = (32'(cnt_q) == N_SCAN - 1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (last_idx) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + SW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign scan_idx_o = cnt_q;

endmodule

`default_nettype wire

### hw/rtl/mrft_datapath.sv
// Datapath of the mesh route forwarding table: item registers, route and peer tables,
// scan records, route count and the output register. Depends on mrft_pkg and mrft_ram.
`default_nettype none

module mrft_datapath #(
  parameter int ROUTE_ENTRIES = mrft_pkg::ROUTE_ENTRIES_DEF,
  parameter int PEER_SLOTS    = mrft_pkg::PEER_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [31:0]         dest_address_i,
  input  wire logic [2:0]          peer_index_i,
  input  wire logic [7:0]          hop_count_i,
  input  wire logic [7:0]          ttl_i,
  input  wire logic [15:0]         packet_length_i,
  input  wire mrft_pkg::mrft_cmd_t cmd_i,
  input  wire logic [$clog2((ROUTE_ENTRIES > PEER_SLOTS) ? ROUTE_ENTRIES : PEER_SLOTS)-1:0]
                                   scan_idx_i,
  output mrft_pkg::mrft_sts_t      sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [3:0]               result_code_o,
  output logic [2:0]               out_peer_o,
  output logic [7:0]               out_ttl_o,
  output logic [4:0]               removed_count_o,
  output logic [4:0]               routes_held_o
);

  localparam int N_SCAN  = (ROUTE_ENTRIES > PEER_SLOTS) ? ROUTE_ENTRIES : PEER_SLOTS;
  localparam int SW      = $clog2(N_SCAN);
  localparam int RW      = $clog2(ROUTE_ENTRIES);
  localparam int PW      = $clog2(PEER_SLOTS);
  localparam int PX_W    = (PW > 3) ? PW : 3;
  localparam int CNT_RAW = $clog2(ROUTE_ENTRIES + 1);
  localparam int CW      = (CNT_RAW > 5) ? CNT_RAW : 5;
  localparam int ROUTE_W = $bits(mrft_pkg::route_t);

  logic [31:0]   my_addr_q;
  logic [2:0]    op_q;
  logic [31:0]   dest_q;
  logic [2:0]    pidx_q;
  logic [7:0]    hops_q;
  logic [7:0]    ttl_q;
  logic [15:0]   len_q;

  logic [ROUTE_ENTRIES-1:0] route_valid_q;
  logic [PEER_SLOTS-1:0]    connected_q;
  logic [CW-1:0]            count_q, count_d;

  logic          s1_v_q;
  logic [SW-1:0] s1_idx_q;

  logic          m_found_q;
  logic [RW-1:0] m_idx_q;
  logic [2:0]    m_peer_q;
  logic [7:0]    m_hops_q;
  logic          f_found_q;
  logic [RW-1:0] f_idx_q;
  logic          p_found_q;
  logic [PW-1:0] p_idx_q;
  logic [CW-1:0] removed_q;

  logic          out_valid_q;
  logic [3:0]    out_rc_q;
  logic [2:0]    out_peer_q;
  logic [7:0]    out_ttl_q;
  logic [4:0]    out_rem_q;
  logic [4:0]    out_cnt_q;

  logic [ROUTE_W-1:0]  route_rdata;
  mrft_pkg::route_t    rd;
  logic [31:0]         peer_rdata;

  logic [PX_W-1:0] pidx_x;
  logic [PX_W-1:0] mpeer_x;
  logic            pok;
  logic            hdr_bad;
  logic            route_ok;

  logic          s1_in_r;
  logic [RW-1:0] ridx;
  logic          r_hit;
  logic          r_free;
  logic          purge;
  logic          s1_in_p;
  logic [PW-1:0] pslot;
  logic          p_hit;

  logic               r_we;
  logic [RW-1:0]      r_waddr;
  mrft_pkg::route_t   r_wdata;
  logic               v_set;
  logic               v_clr;
  logic [RW-1:0]      v_idx;
  logic               cnt_inc;
  logic               cnt_dec;
  logic               p_we;
  logic               conn_set;
  logic               conn_clr;
  logic [3:0]         rc_d;
  logic [2:0]         opeer_d;
  logic [7:0]         ottl_d;
  logic [CW-1:0]      rem_d;

  mrft_ram #(
    .WIDTH(ROUTE_W),
    .DEPTH(ROUTE_ENTRIES)
  ) u_route_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .raddr_i(scan_idx_i[RW-1:0]),
    .rdata_o(route_rdata)
  );

  mrft_ram #(
    .WIDTH(32),
    .DEPTH(PEER_SLOTS)
  ) u_peer_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(pidx_x[PW-1:0]),
    .wdata_i(dest_q),
    .raddr_i(scan_idx_i[PW-1:0]),
    .rdata_o(peer_rdata)
  );

  assign rd      = mrft_pkg::route_t'(route_rdata);
  assign pidx_x  = PX_W'(pidx_q);
  assign mpeer_x = PX_W'(m_peer_q);
  assign pok     = (32'(pidx_q) < PEER_SLOTS);
  assign hdr_bad = (len_q < mrft_pkg::MIN_HEADER_BYTES) || (dest_q == 32'd0);
  assign route_ok = m_found_q && (32'(m_peer_q) < PEER_SLOTS) && connected_q[mpeer_x[PW-1:0]];

  assign s1_in_r = s1_v_q && (32'(s1_idx_q) < ROUTE_ENTRIES);
  assign ridx    = s1_idx_q[RW-1:0];
  assign r_hit   = s1_in_r && route_valid_q[ridx] && (rd.dest == dest_q);
  assign r_free  = s1_in_r && !route_valid_q[ridx];
  assign purge   = s1_in_r && route_valid_q[ridx] && (rd.peer == pidx_q) &&
                   (op_q == mrft_pkg::OP_DOWN) && pok;
  assign s1_in_p = s1_v_q && (32'(s1_idx_q) < PEER_SLOTS);
  assign pslot   = s1_idx_q[PW-1:0];
  assign p_hit   = s1_in_p && connected_q[pslot] && (peer_rdata == dest_q);

  assign sts_o.need_scan = (opcode_i inside {mrft_pkg::OP_OFFER, mrft_pkg::OP_DELETE,
                            mrft_pkg::OP_DOWN, mrft_pkg::OP_FWD, mrft_pkg::OP_LOCAL});
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    r_we     = 1'b0;
    r_waddr  = m_idx_q;
    r_wdata  = '{dest: dest_q, peer: pidx_q, hops: hops_q};
    v_set    = 1'b0;
    v_clr    = 1'b0;
    v_idx    = m_idx_q;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    p_we     = 1'b0;
    conn_set = 1'b0;
    conn_clr = 1'b0;
    rc_d     = mrft_pkg::RC_BAD;
    opeer_d  = 3'd0;
    ottl_d   = 8'd0;
    rem_d    = '0;
    case (op_q)
      mrft_pkg::OP_OFFER: begin
        if (!pok) begin
          rc_d = mrft_pkg::RC_BAD;
        end else if (dest_q == my_addr_q) begin
          rc_d = mrft_pkg::RC_SELF;
        end else if (m_found_q) begin
          if (hops_q < m_hops_q) begin
            r_we = 1'b1;
            rc_d = mrft_pkg::RC_IMPROVED;
          end else begin
            rc_d = mrft_pkg::RC_KEPT;
          end
        end else if (f_found_q) begin
          r_we    = 1'b1;
          r_waddr = f_idx_q;
          v_set   = 1'b1;
          v_idx   = f_idx_q;
          cnt_inc = 1'b1;
          rc_d    = mrft_pkg::RC_ADDED;
        end else begin
          rc_d = mrft_pkg::RC_FULL;
        end
      end
      mrft_pkg::OP_DELETE: begin
        if (m_found_q) begin
          v_clr   = 1'b1;
          cnt_dec = 1'b1;
          rc_d    = mrft_pkg::RC_REMOVED;
        end else begin
          rc_d = mrft_pkg::RC_ABSENT;
        end
      end
      mrft_pkg::OP_HELLO: begin
        if (pok) begin
          p_we     = 1'b1;
          conn_set = 1'b1;
          rc_d     = mrft_pkg::RC_PEER_SET;
        end
      end
      mrft_pkg::OP_DOWN: begin
        if (pok) begin
          conn_clr = 1'b1;
          rem_d    = removed_q;
          rc_d     = mrft_pkg::RC_REMOVED;
        end
      end
      mrft_pkg::OP_FWD: begin
        if (hdr_bad) begin
          rc_d = mrft_pkg::RC_BAD;
        end else if (dest_q == my_addr_q) begin
          rc_d = mrft_pkg::RC_LOCAL;
        end else if (ttl_q <= 8'd1) begin
          rc_d = mrft_pkg::RC_EXPIRED;
        end else if (route_ok) begin
          rc_d    = mrft_pkg::RC_FORWARD;
          opeer_d = m_peer_q;
          ottl_d  = ttl_q - 8'd1;
        end else begin
          rc_d = mrft_pkg::RC_NO_ROUTE;
        end
      end
      mrft_pkg::OP_LOCAL: begin
        if (hdr_bad) begin
          rc_d = mrft_pkg::RC_BAD;
        end else if (p_found_q) begin
          rc_d    = mrft_pkg::RC_FORWARD;
          opeer_d = 3'(p_idx_q);
          ottl_d  = ttl_q;
        end else if (route_ok) begin
          rc_d    = mrft_pkg::RC_FORWARD;
          opeer_d = m_peer_q;
          ottl_d  = ttl_q;
        end else begin
          rc_d = mrft_pkg::RC_NO_ROUTE;
        end
      end
      default: begin
        rc_d = mrft_pkg::RC_BAD;
      end
    endcase
    if (!cmd_i.finish) begin
      r_we     = 1'b0;
      v_set    = 1'b0;
      v_clr    = 1'b0;
      cnt_inc  = 1'b0;
      cnt_dec  = 1'b0;
      p_we     = 1'b0;
      conn_set = 1'b0;
      conn_clr = 1'b0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (purge || cnt_dec) begin
      count_d = count_q - CW'(1);
    end else if (cnt_inc) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_addr_q     <= '0;
      route_valid_q <= '0;
      connected_q   <= '0;
      count_q       <= '0;
      s1_v_q        <= 1'b0;
      m_found_q     <= 1'b0;
      f_found_q     <= 1'b0;
      p_found_q     <= 1'b0;
      removed_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        my_addr_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      s1_v_q  <= cmd_i.issue;
      if (purge) begin
        route_valid_q[ridx] <= 1'b0;
      end
      if (v_set) begin
        route_valid_q[v_idx] <= 1'b1;
      end
      if (v_clr) begin
        route_valid_q[v_idx] <= 1'b0;
      end
      if (conn_set) begin
        connected_q[pidx_x[PW-1:0]] <= 1'b1;
      end
      if (conn_clr) begin
        connected_q[pidx_x[PW-1:0]] <= 1'b0;
      end
      if (cmd_i.load) begin
        m_found_q <= 1'b0;
        f_found_q <= 1'b0;
        p_found_q <= 1'b0;
        removed_q <= '0;
      end else begin
        if (r_hit && !m_found_q) begin
          m_found_q <= 1'b1;
        end
        if (r_free && !f_found_q) begin
          f_found_q <= 1'b1;
        end
        if (p_hit && !p_found_q) begin
          p_found_q <= 1'b1;
        end
        if (purge) begin
          removed_q <= removed_q + CW'(1);
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= scan_idx_i;
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      dest_q <= dest_address_i;
      pidx_q <= peer_index_i;
      hops_q <= hop_count_i;
      ttl_q  <= ttl_i;
      len_q  <= packet_length_i;
    end
    if (r_hit && !m_found_q) begin
      m_idx_q  <= ridx;
      m_peer_q <= rd.peer;
      m_hops_q <= rd.hops;
    end
    if (r_free && !f_found_q) begin
      f_idx_q <= ridx;
    end
    if (p_hit && !p_found_q) begin
      p_idx_q <= pslot;
    end
    if (cmd_i.finish) begin
      out_rc_q   <= rc_d;
      out_peer_q <= opeer_d;
      out_ttl_q  <= ottl_d;
      out_rem_q  <= rem_d[4:0];
      out_cnt_q  <= count_d[4:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_code_o   = out_rc_q;
  assign out_peer_o      = out_peer_q;
  assign out_ttl_o       = out_ttl_q;
  assign removed_count_o = out_rem_q;
  assign routes_held_o   = out_cnt_q;

endmodule

`default_nettype wire

### hw/rtl/mesh_route_forwarding_table.sv
// Top level of the mesh route forwarding table: controller, datapath and tables.
// Depends on mrft_pkg, mrft_ctrl, mrft_datapath and mrft_ram.
//
// Usage: the input channel carries one command per transfer (offer, delete, hello,
// peer down, forward or local send) on in_valid_i / in_ready_o. Each command produces
// exactly one result transfer on out_valid_o / out_ready_i. The own address must be
// written through cfg_we_i / cfg_wdata_i while the block is idle; it is not enforced.
// Throughput: one command is worked on at a time. A hello or an unknown opcode skips the
// scan and goes from the idle state straight to the finish state. Every other command
// walks the route RAM and the peer RAM through their single read ports, one entry per
// cycle, over max(ROUTE_ENTRIES, PEER_SLOTS) entries, then drains and finishes.
// Reset clears the route valid bits, the peer connected flags, the route count and the
// own address at once; no clearing pass is needed and a command is taken right away.
// When the receiver stalls, the result waits in the output register and the next command
// is still taken and worked on; it holds before its result until the register is free.
`default_nettype none

module mesh_route_forwarding_table #(
  parameter int ROUTE_ENTRIES = mrft_pkg::ROUTE_ENTRIES_DEF,
  parameter int PEER_SLOTS    = mrft_pkg::PEER_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] dest_address_i,
  input  wire logic [2:0]  peer_index_i,
  input  wire logic [7:0]  hop_count_i,
  input  wire logic [7:0]  ttl_i,
  input  wire logic [15:0] packet_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       result_code_o,
  output logic [2:0]       out_peer_o,
  output logic [7:0]       out_ttl_o,
  output logic [4:0]       removed_count_o,
  output logic [4:0]       routes_held_o
);

  localparam int N_SCAN = (ROUTE_ENTRIES > PEER_SLOTS) ? ROUTE_ENTRIES : PEER_SLOTS;
  localparam int SW     = $clog2(N_SCAN);

  mrft_pkg::mrft_cmd_t cmd;
  mrft_pkg::mrft_sts_t sts;
  logic [SW-1:0]       scan_idx;

  mrft_ctrl #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .PEER_SLOTS   (PEER_SLOTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .scan_idx_o(scan_idx)
  );

  mrft_datapath #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .PEER_SLOTS   (PEER_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .dest_address_i (dest_address_i),
    .peer_index_i   (peer_index_i),
    .hop_count_i    (hop_count_i),
    .ttl_i          (ttl_i),
    .packet_length_i(packet_length_i),
    .cmd_i          (cmd),
    .scan_idx_i     (scan_idx),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_code_o  (result_code_o),
    .out_peer_o     (out_peer_o),
    .out_ttl_o      (out_ttl_o),
    .removed_count_o(removed_count_o),
    .routes_held_o  (routes_held_o)
  );

endmodule

`default_nettype wire

### hw/rtl/mrft_checker.sv
// Port-level checker for the mesh route forwarding table and its bind statement.
// Depends on mrft_pkg and on the port names of mesh_route_forwarding_table.
`default_nettype none

module mrft_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  result_code_o,
  input wire logic [2:0]  out_peer_o,
  input wire logic [7:0]  out_ttl_o,
  input wire logic [4:0]  removed_count_o
);

  // A stalled result transfer keeps its valid and its code.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_code_o))
    else $error("result changed while stalled");

  // The block works on one command at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command taken while another is in progress");

  // Peer and TTL are only carried by a forward result.
  a_fwd_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o != mrft_pkg::RC_FORWARD) |->
      (out_peer_o == 3'd0) && (out_ttl_o == 8'd0))
    else $error("peer or TTL set on a non-forward result");

  // Purged routes are only reported with a removed result.
  a_removed_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o != mrft_pkg::RC_REMOVED) |-> (removed_count_o == 5'd0))
    else $error("removed count set on a result other than removed");

endmodule

bind mesh_route_forwarding_table mrft_checker u_mrft_checker (.*);

`default_nettype wire
